// ----- rtl/abd_pkg.sv -----
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types and constants of the affine bigram decryptor: register
// indexes, reset values, result codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package abd_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W     = 12;
  localparam int ASZ_W     = 7;
  localparam int LET_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASZ   = 2'd2;

  // Register reset values
  localparam logic [KEY_W-1:0] KEY_A_RST = 12'd1;
  localparam logic [KEY_W-1:0] KEY_B_RST = 12'd0;
  localparam logic [ASZ_W-1:0] ASZ_RST   = 7'd31;

  // Smallest usable alphabet
  localparam int MIN_ALPHABET = 2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LETTER = 2'd1,
    ST_KEY    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_AMOD,
    S_BMOD,
    S_EUC_TEST,
    S_EUC_DIV,
    S_EUC_UPD,
    S_INV,
    S_MUL,
    S_XSTART,
    S_XMOD,
    S_SPLIT,
    S_FINISH
  } state_t;

  // Operand selection of the shared divider
  typedef enum logic [2:0] {
    DIV_KEY_A,
    DIV_KEY_B,
    DIV_EUCLID,
    DIV_PROD,
    DIV_SPLIT
  } div_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     div_start;
    div_sel_t div_sel;
    logic     a_save;
    logic     b_save;
    logic     euc_mul;
    logic     euc_upd;
    logic     inv_calc;
    logic     prod_calc;
    logic     out_load;
    status_t  out_code;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic letter_bad;
    logic div_done;
    logic r1_zero;
    logic r0_one;
  } dp_stat_t;

endpackage

// ----- rtl/abd_div.sv -----
// ----------------------------------------------------------------------------
// abd_div
// Restoring serial divider, one quotient bit per cycle. A long operation
// walks the full dividend; a short one walks only the low SW bits.
// ----------------------------------------------------------------------------
module abd_div #(
  parameter int DW = 26,
  parameter int SW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          short_op,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [SW-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd;
  logic [SW-1:0]    rem;
  logic [SW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SW:0]      partial;
  logic             ge;
  logic [SW:0]      diff;

  // One restoring step
  always_comb begin
    partial = {rem, dvd[DW-1]};
    ge      = (partial >= {1'b0, dvs});
    diff    = partial - {1'b0, dvs};
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= short_op ? CNT_W'(SW) : CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands: load, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= short_op ? (dividend << (DW - SW)) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], ge};
      rem <= ge ? diff[SW-1:0] : partial[SW-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

// ----- rtl/abd_datapath.sv -----
// ----------------------------------------------------------------------------
// abd_datapath
// Configuration registers, operand registers, extended Euclid registers,
// the shared divider and the result register of the bigram decryptor.
// ----------------------------------------------------------------------------
module abd_datapath #(
  parameter int MAX_ALPHABET = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [abd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abd_pkg::KEY_W-1:0]      cfg_data,
  input  logic [abd_pkg::LET_W-1:0]      cipher_first,
  input  logic [abd_pkg::LET_W-1:0]      cipher_second,
  input  abd_pkg::ctrl_cmd_t             cmd,
  output abd_pkg::dp_stat_t              stat,
  output logic [abd_pkg::LET_W-1:0]      plain_first,
  output logic [abd_pkg::LET_W-1:0]      plain_second,
  output logic [1:0]                     status
);

  localparam int M_W   = $clog2(MAX_ALPHABET + 1);
  localparam int SQ_W  = $clog2(MAX_ALPHABET * MAX_ALPHABET + 1);
  localparam int TW    = SQ_W + 2;
  localparam int DW    = (2 * SQ_W > abd_pkg::KEY_W) ? 2 * SQ_W : abd_pkg::KEY_W;
  localparam int CW    = (M_W > abd_pkg::ASZ_W) ? M_W : abd_pkg::ASZ_W;

  // Configuration registers
  logic [abd_pkg::KEY_W-1:0] key_a;
  logic [abd_pkg::KEY_W-1:0] key_b;
  logic [abd_pkg::ASZ_W-1:0] asz;

  // Item registers
  logic [abd_pkg::LET_W-1:0] i1;
  logic [abd_pkg::LET_W-1:0] i2;
  logic [M_W-1:0]            m;
  logic [SQ_W-1:0]           msq;
  logic [SQ_W-1:0]           y;
  logic                      letter_bad;
  logic [SQ_W-1:0]           a_red;
  logic [SQ_W-1:0]           b_red;
  logic [SQ_W-1:0]           r0;
  logic [SQ_W-1:0]           r1;
  logic signed [TW-1:0]      t0;
  logic signed [TW-1:0]      t1;
  logic signed [TW-1:0]      tq;
  logic [SQ_W-1:0]           inv;
  logic [SQ_W-1:0]           z;
  logic [DW-1:0]             prod;

  // Result register
  logic [abd_pkg::LET_W-1:0] plain_first_r;
  logic [abd_pkg::LET_W-1:0] plain_second_r;
  abd_pkg::status_t          status_r;

  // Combinational helpers
  logic [CW-1:0]        asz_ext;
  logic [M_W-1:0]       m_sat;
  logic [DW-1:0]        div_dividend;
  logic [SQ_W-1:0]      div_divisor;
  logic                 div_short;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic [SQ_W-1:0]      div_rem;
  logic signed [TW-1:0] q_s;
  logic signed [TW-1:0] msq_s;
  logic signed [TW-1:0] t0_pos;
  logic signed [TW-1:0] inv_val;
  logic [SQ_W:0]        z_val;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= abd_pkg::KEY_A_RST;
      key_b <= abd_pkg::KEY_B_RST;
      asz   <= abd_pkg::ASZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abd_pkg::CFG_KEY_A: key_a <= cfg_data;
        abd_pkg::CFG_KEY_B: key_b <= cfg_data;
        abd_pkg::CFG_ASZ:   asz   <= cfg_data[abd_pkg::ASZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the alphabet size into the supported range
  always_comb begin
    asz_ext = CW'(asz);
    if (asz_ext < CW'(abd_pkg::MIN_ALPHABET)) begin
      m_sat = M_W'(abd_pkg::MIN_ALPHABET);
    end else if (asz_ext > CW'(MAX_ALPHABET)) begin
      m_sat = M_W'(MAX_ALPHABET);
    end else begin
      m_sat = M_W'(asz_ext);
    end
  end

  // Pick divider operands
  always_comb begin
    div_dividend = DW'(key_a);
    div_divisor  = msq;
    div_short    = 1'b0;
    unique case (cmd.div_sel)
      abd_pkg::DIV_KEY_A: begin
        div_dividend = DW'(key_a);
        div_divisor  = msq;
      end
      abd_pkg::DIV_KEY_B: begin
        div_dividend = DW'(key_b);
        div_divisor  = msq;
      end
      abd_pkg::DIV_EUCLID: begin
        div_dividend = DW'(r0);
        div_divisor  = r1;
        div_short    = 1'b1;
      end
      abd_pkg::DIV_PROD: begin
        div_dividend = prod;
        div_divisor  = msq;
      end
      abd_pkg::DIV_SPLIT: begin
        div_dividend = DW'(div_rem);
        div_divisor  = SQ_W'(m);
        div_short    = 1'b1;
      end
      default: ;
    endcase
  end

  abd_div #(
    .DW (DW),
    .SW (SQ_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .short_op  (div_short),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Signed views of the Euclid quotient and the modulus
  always_comb begin
    q_s   = $signed(TW'(div_quo[SQ_W-1:0]));
    msq_s = $signed(TW'(msq));
  end

  // Bring the Bezout coefficient into range, and form y - b mod msq
  always_comb begin
    t0_pos  = t0[TW-1] ? (t0 + msq_s) : t0;
    inv_val = (t0_pos >= msq_s) ? (t0_pos - msq_s) : t0_pos;
    if (y >= b_red) begin
      z_val = {1'b0, y} - {1'b0, b_red};
    end else begin
      z_val = {1'b0, y} + {1'b0, msq} - {1'b0, b_red};
    end
  end

  // Latch the word and the clamped alphabet size
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      i1 <= cipher_first;
      i2 <= cipher_second;
      m  <= m_sat;
    end
  end

  // Modulus, bigram value and letter check
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      msq        <= SQ_W'(m) * SQ_W'(m);
      y          <= SQ_W'(i1) * SQ_W'(m) + SQ_W'(i2);
      letter_bad <= (CW'(i1) >= CW'(m)) || (CW'(i2) >= CW'(m));
    end
  end

  // Reduced keys; saving key b also loads the Euclid start values
  always_ff @(posedge clk) begin
    if (cmd.a_save) begin
      a_red <= div_rem;
    end
    if (cmd.b_save) begin
      b_red <= div_rem;
    end
  end

  // Extended Euclid registers
  always_ff @(posedge clk) begin
    if (cmd.b_save) begin
      r0 <= msq;
      r1 <= a_red;
      t0 <= '0;
      t1 <= TW'(1);
    end else if (cmd.euc_upd) begin
      r0 <= r1;
      r1 <= div_rem;
      t0 <= t1;
      t1 <= t0 - tq;
    end
  end

  // Quotient times coefficient, registered before the subtract
  always_ff @(posedge clk) begin
    if (cmd.euc_mul) begin
      tq <= q_s * t1;
    end
  end

  // Inverse and key-shifted value, then their product
  always_ff @(posedge clk) begin
    if (cmd.inv_calc) begin
      inv <= SQ_W'(inv_val);
      z   <= z_val[SQ_W-1:0];
    end
    if (cmd.prod_calc) begin
      prod <= DW'(inv) * DW'(z);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_code;
      if (cmd.out_code == abd_pkg::ST_OK) begin
        plain_first_r  <= abd_pkg::LET_W'(div_quo[SQ_W-1:0]);
        plain_second_r <= abd_pkg::LET_W'(div_rem);
      end else begin
        plain_first_r  <= '0;
        plain_second_r <= '0;
      end
    end
  end

  always_comb begin
    stat.letter_bad = letter_bad;
    stat.div_done   = div_done;
    stat.r1_zero    = (r1 == '0);
    stat.r0_one     = (r0 == SQ_W'(1));
  end

  assign plain_first  = plain_first_r;
  assign plain_second = plain_second_r;
  assign status       = status_r;

endmodule

// ----- rtl/abd_ctrl.sv -----
// ----------------------------------------------------------------------------
// abd_ctrl
// Sequencer of the bigram decryptor: runs key reduction, the extended
// Euclid loop and the final decode through the datapath, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module abd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  abd_pkg::dp_stat_t  stat,
  output abd_pkg::ctrl_cmd_t cmd
);

  abd_pkg::state_t  state;
  abd_pkg::state_t  state_next;
  abd_pkg::status_t code;
  abd_pkg::status_t code_next;
  logic             out_valid_r;

  // State, result code and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= abd_pkg::S_IDLE;
      code        <= abd_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    code_next    = code;
    cmd          = '0;
    cmd.div_sel  = abd_pkg::DIV_KEY_A;
    cmd.out_code = code;
    in_ready     = 1'b0;
    unique case (state)
      abd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = abd_pkg::S_SETUP;
        end
      end
      abd_pkg::S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = abd_pkg::S_CHECK;
      end
      abd_pkg::S_CHECK: begin
        // Drop to the result on a letter outside the alphabet
        if (stat.letter_bad) begin
          code_next  = abd_pkg::ST_LETTER;
          state_next = abd_pkg::S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = abd_pkg::DIV_KEY_A;
          state_next    = abd_pkg::S_AMOD;
        end
      end
      abd_pkg::S_AMOD: begin
        if (stat.div_done) begin
          cmd.a_save    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = abd_pkg::DIV_KEY_B;
          state_next    = abd_pkg::S_BMOD;
        end
      end
      abd_pkg::S_BMOD: begin
        if (stat.div_done) begin
          cmd.b_save = 1'b1;
          state_next = abd_pkg::S_EUC_TEST;
        end
      end
      abd_pkg::S_EUC_TEST: begin
        if (stat.r1_zero) begin
          state_next = abd_pkg::S_INV;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = abd_pkg::DIV_EUCLID;
          state_next    = abd_pkg::S_EUC_DIV;
        end
      end
      abd_pkg::S_EUC_DIV: begin
        cmd.div_sel = abd_pkg::DIV_EUCLID;
        if (stat.div_done) begin
          cmd.euc_mul = 1'b1;
          state_next  = abd_pkg::S_EUC_UPD;
        end
      end
      abd_pkg::S_EUC_UPD: begin
        cmd.euc_upd = 1'b1;
        state_next  = abd_pkg::S_EUC_TEST;
      end
      abd_pkg::S_INV: begin
        // Key has no inverse unless the gcd came out as one
        if (!stat.r0_one) begin
          code_next  = abd_pkg::ST_KEY;
          state_next = abd_pkg::S_FINISH;
        end else begin
          cmd.inv_calc = 1'b1;
          state_next   = abd_pkg::S_MUL;
        end
      end
      abd_pkg::S_MUL: begin
        cmd.prod_calc = 1'b1;
        state_next    = abd_pkg::S_XSTART;
      end
      abd_pkg::S_XSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = abd_pkg::DIV_PROD;
        state_next    = abd_pkg::S_XMOD;
      end
      abd_pkg::S_XMOD: begin
        cmd.div_sel = abd_pkg::DIV_PROD;
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = abd_pkg::DIV_SPLIT;
          state_next    = abd_pkg::S_SPLIT;
        end
      end
      abd_pkg::S_SPLIT: begin
        cmd.div_sel = abd_pkg::DIV_SPLIT;
        if (stat.div_done) begin
          code_next  = abd_pkg::ST_OK;
          state_next = abd_pkg::S_FINISH;
        end
      end
      abd_pkg::S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = abd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = abd_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/affine_bigram_decrypt.sv -----
// ----------------------------------------------------------------------------
// affine_bigram_decrypt
// Decrypts one affine-cipher bigram per word: y = first*m + second, and
// x = a^-1 * (y - b) mod m*m, returned as the letter pair x/m, x%m. The
// alphabet size m is clamped to 2..MAX_ALPHABET and both keys are reduced
// mod m*m. A letter index of m or more gives status 1, a key a with no
// inverse mod m*m gives status 2; both return zero letters. One word is in
// work at a time; a new one is taken as soon as the previous result sits in
// the output register. One shared serial divider (one quotient bit per
// cycle) serves the key reductions, every Euclid step and the final decode.
// Configuration registers are written directly by index and must only
// change while the block is idle.
// ----------------------------------------------------------------------------
module affine_bigram_decrypt #(
  parameter int MAX_ALPHABET = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [abd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abd_pkg::KEY_W-1:0]     cfg_data,
  // Ciphertext words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [abd_pkg::LET_W-1:0]     cipher_first,
  input  logic [abd_pkg::LET_W-1:0]     cipher_second,
  // Plaintext words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [abd_pkg::LET_W-1:0]     plain_first,
  output logic [abd_pkg::LET_W-1:0]     plain_second,
  output logic [1:0]                    status
);

  abd_pkg::ctrl_cmd_t cmd;
  abd_pkg::dp_stat_t  stat;

  abd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  abd_datapath #(
    .MAX_ALPHABET (MAX_ALPHABET)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second),
    .cmd           (cmd),
    .stat          (stat),
    .plain_first   (plain_first),
    .plain_second  (plain_second),
    .status        (status)
  );

endmodule
